// ===== sv/hucs_pkg.sv =====
// ----------------------------------------------------------------------------
// hucs_pkg: shared codes and types for the URI component splitter
// Parse position codes, component tags, delimiter bytes and the step result.
// ----------------------------------------------------------------------------
`default_nettype none

package hucs_pkg;

    localparam int CHAR_W = 8;
    localparam int POS_W  = 4;
    localparam int COMP_W = 3;

    localparam logic [POS_W-1:0] POS_START    = 4'd0;
    localparam logic [POS_W-1:0] POS_SCHEME   = 4'd1;
    localparam logic [POS_W-1:0] POS_COLON    = 4'd2;
    localparam logic [POS_W-1:0] POS_SLASH1   = 4'd3;
    localparam logic [POS_W-1:0] POS_HOST     = 4'd4;
    localparam logic [POS_W-1:0] POS_PORT     = 4'd5;
    localparam logic [POS_W-1:0] POS_PATH     = 4'd6;
    localparam logic [POS_W-1:0] POS_QUERY    = 4'd7;
    localparam logic [POS_W-1:0] POS_FRAGMENT = 4'd8;

    localparam logic [COMP_W-1:0] COMP_NONE     = 3'd0;
    localparam logic [COMP_W-1:0] COMP_SCHEME   = 3'd1;
    localparam logic [COMP_W-1:0] COMP_HOST     = 3'd2;
    localparam logic [COMP_W-1:0] COMP_PORT     = 3'd3;
    localparam logic [COMP_W-1:0] COMP_PATH     = 3'd4;
    localparam logic [COMP_W-1:0] COMP_QUERY    = 3'd5;
    localparam logic [COMP_W-1:0] COMP_FRAGMENT = 3'd6;

    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
    localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3f;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;

    typedef struct packed {
        logic              rejected;
        logic [COMP_W-1:0] component;
        logic [POS_W-1:0]  pos_next;
    } hucs_step_t;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    function automatic logic is_dec_char(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

`default_nettype wire

// ===== sv/hucs_if.sv =====
// ----------------------------------------------------------------------------
// hucs_if: valid/ready channels of the URI component splitter
// Request channel carries one URI byte, result channel one tagged byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface hucs_req_if;
    logic                      valid;
    logic                      ready;
    logic [hucs_pkg::CHAR_W-1:0] char_in;
    logic                      restart;

    modport source (output valid, output char_in, output restart, input ready);
    modport sink   (input valid, input char_in, input restart, output ready);
endinterface

interface hucs_res_if;
    logic                        valid;
    logic                        ready;
    logic                        rejected;
    logic [hucs_pkg::COMP_W-1:0] component;
    logic [hucs_pkg::CHAR_W-1:0] char_out;

    modport source (output valid, output rejected, output component, output char_out,
                    input ready);
    modport sink   (input valid, input rejected, input component, input char_out,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/hucs_transition.sv =====
// ----------------------------------------------------------------------------
// hucs_transition: one grammar step of the URI parser
// Maps the current parse position and a byte to the tag and next position.
// ----------------------------------------------------------------------------
`default_nettype none

module hucs_transition (
    input  wire logic [hucs_pkg::POS_W-1:0]  pos,
    input  wire logic [hucs_pkg::CHAR_W-1:0] char_in,
    input  wire logic                        restart,
    output hucs_pkg::hucs_step_t             step
);
    import hucs_pkg::*;

    logic [POS_W-1:0]  cur;
    logic [POS_W-1:0]  nxt;
    logic [COMP_W-1:0] comp;
    logic              ok;

    always_comb
    begin
        cur  = restart ? POS_START : pos;
        nxt  = cur;
        comp = COMP_NONE;
        ok   = 1'b1;
        case (cur)
            POS_START:
            begin
                if (char_in == CH_SLASH)
                begin
                    nxt  = POS_PATH;
                    comp = COMP_PATH;
                end
                else if (is_letter(char_in))
                begin
                    nxt  = POS_SCHEME;
                    comp = COMP_SCHEME;
                end
                else
                    ok = 1'b0;
            end
            POS_SCHEME:
            begin
                if (is_letter(char_in))
                    comp = COMP_SCHEME;
                else if (char_in == CH_COLON)
                    nxt = POS_COLON;
                else
                    ok = 1'b0;
            end
            POS_COLON:
            begin
                if (char_in == CH_SLASH)
                    nxt = POS_SLASH1;
                else
                    ok = 1'b0;
            end
            POS_SLASH1:
            begin
                if (char_in == CH_SLASH)
                    nxt = POS_HOST;
                else
                    ok = 1'b0;
            end
            POS_HOST:
            begin
                if (char_in == CH_SLASH)
                    nxt = POS_PATH;
                else if (char_in == CH_COLON)
                    nxt = POS_PORT;
                else
                    comp = COMP_HOST;
            end
            POS_PORT:
            begin
                if (is_dec_char(char_in))
                    comp = COMP_PORT;
                else if (char_in == CH_SLASH)
                    nxt = POS_PATH;
                else
                    ok = 1'b0;
            end
            POS_PATH:
            begin
                if (char_in == CH_QUEST)
                    nxt = POS_QUERY;
                else if (char_in == CH_HASH)
                    nxt = POS_FRAGMENT;
                else
                    comp = COMP_PATH;
            end
            POS_QUERY:
            begin
                if (char_in == CH_HASH)
                    nxt = POS_FRAGMENT;
                else
                    comp = COMP_QUERY;
            end
            POS_FRAGMENT:
                comp = COMP_FRAGMENT;
            default:
                ok = 1'b0;
        endcase

        // rejected byte keeps the position and carries no tag
        step.rejected  = ~ok;
        step.component = ok ? comp : COMP_NONE;
        step.pos_next  = ok ? nxt : cur;
    end

endmodule

`default_nettype wire

// ===== sv/http_uri_component_splitter.sv =====
// ----------------------------------------------------------------------------
// http_uri_component_splitter: tags each byte of a request-URI by component
// Input register, one grammar step, result register; one byte per cycle unless res stalls.
// ----------------------------------------------------------------------------
// Usage
//   req carries one URI byte (char_in) and a restart flag per request; set
//   restart on the first byte of a URI to begin a fresh parse.
//   res returns one result per request, in order: rejected, component
//   (0 none .. 6 fragment) and the byte itself as char_out.
//   Path: a taken request is held in the input register, then passes the
//   grammar step into the result register once res is not stalled.
//   Throughput: one byte per cycle while res is not stalled; the position
//   register is read and written by the single transition step per byte.
//   Stall: while res.valid waits for res.ready, one more request can sit in
//   the input register; req.ready drops only when both stages are full.
//   Reset: rst_n clears both stages and sets the position to start.
// ----------------------------------------------------------------------------
`default_nettype none

module http_uri_component_splitter (
    input  wire logic clk,
    input  wire logic rst_n,
    hucs_req_if.sink   req,
    hucs_res_if.source res
);
    import hucs_pkg::*;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_restart_reg;

    logic              res_valid_reg;
    logic              res_rejected_reg;
    logic [COMP_W-1:0] res_comp_reg;
    logic [CHAR_W-1:0] res_char_reg;

    logic [POS_W-1:0]  pos_reg;
    hucs_step_t        step;

    logic              out_free;
    logic              move;

    assign out_free  = ~res_valid_reg | res.ready;
    assign move      = in_valid_reg & out_free;
    assign req.ready = ~in_valid_reg | out_free;

    hucs_transition u_transition (
        .pos     (pos_reg),
        .char_in (in_char_reg),
        .restart (in_restart_reg),
        .step    (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pos_reg       <= POS_START;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (out_free)
                res_valid_reg <= in_valid_reg;
            if (move)
                pos_reg <= step.pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_char_reg    <= req.char_in;
            in_restart_reg <= req.restart;
        end
        if (move)
        begin
            res_rejected_reg <= step.rejected;
            res_comp_reg     <= step.component;
            res_char_reg     <= in_char_reg;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.rejected  = res_rejected_reg;
    assign res.component = res_comp_reg;
    assign res.char_out  = res_char_reg;

endmodule

`default_nettype wire

// ===== sv/hucs_checker.sv =====
// ----------------------------------------------------------------------------
// hucs_checker: port-level checks for the URI component splitter
// Result hold under stall, tag range, untagged rejects and tags against the byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hucs_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        res_valid,
    input wire logic                        res_ready,
    input wire logic                        res_rejected,
    input wire logic [hucs_pkg::COMP_W-1:0] res_component,
    input wire logic [hucs_pkg::CHAR_W-1:0] res_char_out
);
    import hucs_pkg::*;

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // rejected bytes never carry a tag
    a_reject_untagged: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_rejected |-> res_component == COMP_NONE)
        else $error("rejected byte tagged");

    a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_component <= COMP_FRAGMENT)
        else $error("component code out of range");

    a_port_digit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_component == COMP_PORT |-> is_dec_char(res_char_out))
        else $error("port tag on non-digit byte");

    // the fragment delimiter never ends up inside a query
    a_query_hash: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_component == COMP_QUERY |-> res_char_out != CH_HASH)
        else $error("hash tagged as query");

endmodule

bind http_uri_component_splitter hucs_checker u_hucs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_rejected  (res.rejected),
    .res_component (res.component),
    .res_char_out  (res.char_out)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for http_uri_component_splitter
// A directed table runs through each parse state, its delimiters and its
// rejections. Random URIs follow: mostly well formed, some broken or noisy.
// Typed rows are scored against the table, all others against a behavioural parser.
// Both channels stall at random, with some calm stretches between.
// ----------------------------------------------------------------------------
module tb;
    import hucs_pkg::*;

    typedef struct packed {
        logic              rejected;
        logic [COMP_W-1:0] component;
        logic [CHAR_W-1:0] char_out;
    } uri_tag_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              rs;
        logic              typed;
        logic              rej;
        logic [COMP_W-1:0] comp;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    hucs_req_if req_ch ();
    hucs_res_if res_ch ();

    http_uri_component_splitter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    always #5 clk = ~clk;

    logic [POS_W-1:0] uri_pos = POS_START;
    uri_tag_t         pending_tags [$];
    uri_tag_t         exp_tag;
    int               err_cnt = 0;
    int               sent = 0;
    int               rx_hold = 0;
    logic             calm = 1'b0;

    dir_row_t dir_rows [25] = '{
        '{8'h00,    1'b0, 1'b1, 1'b1, COMP_NONE},
        '{8'hff,    1'b0, 1'b1, 1'b1, COMP_NONE},
        '{CH_SLASH, 1'b1, 1'b1, 1'b0, COMP_PATH},
        '{CH_QUEST, 1'b0, 1'b1, 1'b0, COMP_NONE},
        '{8'h61,    1'b0, 1'b1, 1'b0, COMP_QUERY},
        '{CH_HASH,  1'b0, 1'b1, 1'b0, COMP_NONE},
        '{8'hff,    1'b0, 1'b1, 1'b0, COMP_FRAGMENT},
        '{CH_HASH,  1'b0, 1'b1, 1'b0, COMP_FRAGMENT},
        '{8'h00,    1'b1, 1'b1, 1'b1, COMP_NONE},
        '{8'h41,    1'b0, 1'b1, 1'b0, COMP_SCHEME},
        '{8'h7a,    1'b0, 1'b1, 1'b0, COMP_SCHEME},
        '{8'h39,    1'b0, 1'b1, 1'b1, COMP_NONE},
        '{CH_COLON, 1'b0, 1'b1, 1'b0, COMP_NONE},
        '{8'h61,    1'b0, 1'b1, 1'b1, COMP_NONE},
        '{CH_SLASH, 1'b0, 1'b1, 1'b0, COMP_NONE},
        '{CH_COLON, 1'b0, 1'b1, 1'b1, COMP_NONE},
        '{CH_SLASH, 1'b0, 1'b1, 1'b0, COMP_NONE},
        '{CH_QUEST, 1'b0, 1'b1, 1'b0, COMP_HOST},
        '{8'h80,    1'b0, 1'b0, 1'b0, COMP_NONE},
        '{CH_COLON, 1'b0, 1'b1, 1'b0, COMP_NONE},
        '{8'h30,    1'b0, 1'b1, 1'b0, COMP_PORT},
        '{8'h7f,    1'b0, 1'b1, 1'b1, COMP_NONE},
        '{CH_SLASH, 1'b0, 1'b1, 1'b0, COMP_NONE},
        '{8'h5a,    1'b0, 1'b0, 1'b0, COMP_NONE},
        '{8'h40,    1'b1, 1'b0, 1'b0, COMP_NONE}
    };

    function automatic logic alpha(input logic [CHAR_W-1:0] c);
        return (c inside {[8'h41:8'h5a], [8'h61:8'h7a]});
    endfunction

    function automatic logic numeral(input logic [CHAR_W-1:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    // advances the bench copy of the parse position
    function automatic uri_tag_t classify_byte(input logic [CHAR_W-1:0] c, input logic rs);
        logic [POS_W-1:0]  nxt;
        logic [COMP_W-1:0] comp;
        logic              ok;
        uri_tag_t          t;
        if (rs)
            uri_pos = POS_START;
        nxt  = uri_pos;
        comp = COMP_NONE;
        ok   = 1'b1;
        case (uri_pos)
            POS_START:
                if (c == CH_SLASH)
                begin
                    nxt  = POS_PATH;
                    comp = COMP_PATH;
                end
                else if (alpha(c))
                begin
                    nxt  = POS_SCHEME;
                    comp = COMP_SCHEME;
                end
                else
                    ok = 1'b0;
            POS_SCHEME:
                if (alpha(c))
                    comp = COMP_SCHEME;
                else if (c == CH_COLON)
                    nxt = POS_COLON;
                else
                    ok = 1'b0;
            POS_COLON:
                if (c == CH_SLASH)
                    nxt = POS_SLASH1;
                else
                    ok = 1'b0;
            POS_SLASH1:
                if (c == CH_SLASH)
                    nxt = POS_HOST;
                else
                    ok = 1'b0;
            POS_HOST:
                if (c == CH_SLASH)
                    nxt = POS_PATH;
                else if (c == CH_COLON)
                    nxt = POS_PORT;
                else
                    comp = COMP_HOST;
            POS_PORT:
                if (numeral(c))
                    comp = COMP_PORT;
                else if (c == CH_SLASH)
                    nxt = POS_PATH;
                else
                    ok = 1'b0;
            POS_PATH:
                if (c == CH_QUEST)
                    nxt = POS_QUERY;
                else if (c == CH_HASH)
                    nxt = POS_FRAGMENT;
                else
                    comp = COMP_PATH;
            POS_QUERY:
                if (c == CH_HASH)
                    nxt = POS_FRAGMENT;
                else
                    comp = COMP_QUERY;
            POS_FRAGMENT:
                comp = COMP_FRAGMENT;
            default:
                ok = 1'b0;
        endcase
        if (ok)
            uri_pos = nxt;
        else
            comp = COMP_NONE;
        t.rejected  = !ok;
        t.component = comp;
        t.char_out  = c;
        return t;
    endfunction

    function automatic int gap_cycles();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_letter();
        if ($urandom_range(0, 1))
            return CHAR_W'(8'h41 + $urandom_range(0, 25));
        return CHAR_W'(8'h61 + $urandom_range(0, 25));
    endfunction

    // delimiters drawn often so they land inside host, path, query and fragment
    function automatic logic [CHAR_W-1:0] any_but(input logic [CHAR_W-1:0] x0,
                                                 input logic [CHAR_W-1:0] x1);
        logic [CHAR_W-1:0] c;
        do
        begin
            case ($urandom_range(0, 15))
                0:       c = CH_SLASH;
                1:       c = CH_COLON;
                2:       c = CH_QUEST;
                3:       c = CH_HASH;
                default: c = CHAR_W'($urandom_range(0, 255));
            endcase
        end
        while (c == x0 || c == x1);
        return c;
    endfunction

    task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic rs,
                             input logic typed, input uri_tag_t want);
        uri_tag_t guess;
        int       gap;
        req_ch.valid   <= 1'b1;
        req_ch.char_in <= ch;
        req_ch.restart <= rs;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        guess = classify_byte(ch, rs);
        pending_tags = {pending_tags, (typed ? want : guess)};
        sent++;
        gap = gap_cycles();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tags.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (res_ch.valid && res_ch.ready)
        begin
            if (pending_tags.size() == 0)
            begin
                $error("unexpected result, char_out %0h", res_ch.char_out);
                err_cnt++;
            end
            else
            begin
                exp_tag = pending_tags.pop_front();
                if (res_ch.rejected !== exp_tag.rejected)
                begin
                    $error("rejected: expected %0d, got %0d", exp_tag.rejected,
                           res_ch.rejected);
                    err_cnt++;
                end
                if (res_ch.component !== exp_tag.component)
                begin
                    $error("component: expected %0d, got %0d", exp_tag.component,
                           res_ch.component);
                    err_cnt++;
                end
                if (res_ch.char_out !== exp_tag.char_out)
                begin
                    $error("char_out: expected %0h, got %0h", exp_tag.char_out,
                           res_ch.char_out);
                    err_cnt++;
                end
            end
        end
        if (rx_hold != 0)
        begin
            rx_hold--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            rx_hold = gap_cycles();
        end
    end

    initial
    begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        uri_tag_t          want;
        logic [CHAR_W:0]   uri_q [$];
        logic [CHAR_W-1:0] b;
        int                kind;
        int                k;
        logic              paused;
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.char_in <= '0;
        req_ch.restart <= 1'b0;
        paused = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            want.rejected  = dir_rows[i].rej;
            want.component = dir_rows[i].comp;
            want.char_out  = dir_rows[i].ch;
            send_byte(dir_rows[i].ch, dir_rows[i].rs, dir_rows[i].typed, want);
        end
        drain();

        want = '0;
        while (sent < 1030)
        begin
            calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            uri_q.delete();
            if (kind < 3)
                uri_q = {uri_q, {1'b1, CH_SLASH}};
            else if (kind < 9)
            begin
                uri_q = {uri_q, {1'b1, rand_letter()}};
                repeat ($urandom_range(0, 5)) uri_q = {uri_q, {1'b0, rand_letter()}};
                uri_q = {uri_q, {1'b0, CH_COLON}};
                uri_q = {uri_q, {1'b0, CH_SLASH}};
                uri_q = {uri_q, {1'b0, CH_SLASH}};
                repeat ($urandom_range(0, 8))
                    uri_q = {uri_q, {1'b0, any_but(CH_SLASH, CH_COLON)}};
                if ($urandom_range(0, 1))
                begin
                    uri_q = {uri_q, {1'b0, CH_COLON}};
                    repeat ($urandom_range(0, 5))
                        uri_q = {uri_q, {1'b0, CHAR_W'(8'h30 + $urandom_range(0, 9))}};
                end
                if ($urandom_range(0, 5) != 0)
                    uri_q = {uri_q, {1'b0, CH_SLASH}};
            end
            else
                repeat ($urandom_range(1, 8))
                    uri_q = {uri_q, {($urandom_range(0, 7) == 0),
                                     CHAR_W'($urandom_range(0, 255))}};
            if (kind < 9)
            begin
                repeat ($urandom_range(0, 8))
                    uri_q = {uri_q, {1'b0, any_but(CH_QUEST, CH_HASH)}};
                if ($urandom_range(0, 1))
                begin
                    uri_q = {uri_q, {1'b0, CH_QUEST}};
                    repeat ($urandom_range(0, 6))
                        uri_q = {uri_q, {1'b0, any_but(CH_HASH, CH_HASH)}};
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    uri_q = {uri_q, {1'b0, CH_HASH}};
                    repeat ($urandom_range(0, 6))
                        uri_q = {uri_q, {1'b0, any_but(8'h00, 8'h00)}};
                end
            end
            // broken sequences: a stray byte or a missing restart
            if (uri_q.size() > 1 && $urandom_range(0, 3) == 0)
            begin
                k = $urandom_range(1, uri_q.size() - 1);
                uri_q[k] = {1'b0, CHAR_W'($urandom_range(0, 255))};
            end
            if ($urandom_range(0, 9) == 0)
                uri_q[0][CHAR_W] = 1'b0;
            foreach (uri_q[j])
            begin
                b = uri_q[j][CHAR_W-1:0];
                send_byte(b, uri_q[j][CHAR_W], 1'b0, want);
            end
            if (!paused && sent >= 550)
            begin
                paused = 1'b1;
                drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
